// File: rtl/bfei_pkg.sv
// ----------------------------------------------------------------------------
// bfei_pkg
// Shared constants, types and helpers for the MSB-first bit field
// extract/insert block.
// ----------------------------------------------------------------------------
package bfei_pkg;

  // Buffer geometry and field limits
  localparam int BUFFER_BYTES   = 64;
  localparam int MAX_FIELD_BITS = 32;
  localparam int TOTAL_BITS     = 8 * BUFFER_BYTES;
  localparam int ADDR_W         = $clog2(BUFFER_BYTES);

  // Worst-case number of bytes a field touches (start offset up to 7 bits)
  localparam int MAX_SPAN = (MAX_FIELD_BITS + 14) / 8;
  localparam int WIN_W    = 8 * MAX_SPAN;
  localparam int SH_W     = $clog2(WIN_W);
  localparam int CNT_W    = $clog2(MAX_SPAN + 1);

  // Transaction field widths
  localparam int OP_W  = 3;
  localparam int IDX_W = 6;
  localparam int POS_W = 9;
  localparam int LEN_W = 6;
  localparam int VAL_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_BYTE    = 3'd0,
    OP_READ_BYTE    = 3'd1,
    OP_GET_UNSIGNED = 3'd2,
    OP_GET_SIGNED   = 3'd3,
    OP_SET_FIELD    = 3'd4
  } op_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic [WIN_W-1:0] word;
    logic [SH_W-1:0]  amt;
    logic             left;
  } shift_req_t;

  // Low len bits set
  function automatic logic [VAL_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [VAL_W:0] t;
    t = ((VAL_W + 1)'(1) << len) - (VAL_W + 1)'(1);
    return t[VAL_W-1:0];
  endfunction

endpackage

// File: rtl/bfei_mem.sv
// ----------------------------------------------------------------------------
// bfei_mem
// Byte buffer: one write port, one registered read port. Per-byte valid
// flags make the whole buffer read as zero right after reset.
// ----------------------------------------------------------------------------
module bfei_mem
  import bfei_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mem_wr_t    wr_i,
  input  mem_rd_t    rd_i,
  output logic [7:0] rdata_o
);

  logic [7:0]              mem_q [BUFFER_BYTES];
  logic [BUFFER_BYTES-1:0] valid_q;
  logic [7:0]              raw_q;
  logic                    rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.re) begin
      raw_q <= mem_q[rd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.we) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.re) begin
        rd_valid_q <= valid_q[rd_i.addr];
      end
    end
  end

  assign rdata_o = rd_valid_q ? raw_q : 8'h00;

endmodule

// File: rtl/bfei_shift.sv
// ----------------------------------------------------------------------------
// bfei_shift
// Shared window shifter: aligns insert data and masks, and pulls an
// extracted field down to bit 0.
// ----------------------------------------------------------------------------
module bfei_shift
  import bfei_pkg::*;
(
  input  shift_req_t       req_i,
  output logic [WIN_W-1:0] word_o
);

  assign word_o = req_i.left ? (req_i.word << req_i.amt) : (req_i.word >> req_i.amt);

endmodule

// File: rtl/bit_field_extract_insert.sv
// ----------------------------------------------------------------------------
// bit_field_extract_insert
// Flow: load byte and rejected/no-op transactions go straight to the result; read
//   byte and get field read the spanned bytes (n = 1..5), then extract; set field
//   aligns data and mask, then rewrites the spanned bytes. The single buffer read
//   port streams one byte per cycle; a new transaction waits until the result is taken.
// Reset: asynchronous, active low; buffer reads as all zero after reset.
// ----------------------------------------------------------------------------
module bit_field_extract_insert
  import bfei_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // request channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [OP_W-1:0]  operation_i,
  input  logic [IDX_W-1:0] byte_index_i,
  input  logic [POS_W-1:0] bit_position_i,
  input  logic [LEN_W-1:0] field_length_i,
  input  logic [VAL_W-1:0] write_value_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [VAL_W-1:0] result_value_o,
  output logic             status_o
);

  // Sequencer: IDLE decodes, ALIGN_D/ALIGN_M prepare insert data and mask
  // through the shared shifter, BYTES streams the spanned bytes through the
  // buffer (read k+1 while merging/capturing k), EXTRACT shifts the field
  // down, DONE holds the result until taken.
  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_ALIGN_D = 6'b000010,
    S_ALIGN_M = 6'b000100,
    S_BYTES   = 6'b001000,
    S_EXTRACT = 6'b010000,
    S_DONE    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // control
  logic             pend_q, pend_d;
  logic [CNT_W-1:0] rd_k_q, rd_k_d;
  logic [CNT_W-1:0] cap_k_q, cap_k_d;

  // payload
  logic              set_q, set_d;
  logic              signed_q, signed_d;
  logic [ADDR_W-1:0] b0_q, b0_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [SH_W-1:0]   sh_q, sh_d;
  logic [VAL_W-1:0]  val_q, val_d;
  logic [WIN_W-1:0]  data_q, data_d;
  logic [WIN_W-1:0]  mask_q, mask_d;
  logic [WIN_W-1:0]  win_q, win_d;
  logic [VAL_W-1:0]  res_q, res_d;
  logic              status_q, status_d;

  mem_wr_t          mem_wr;
  mem_rd_t          mem_rd;
  logic [7:0]       rdata;
  shift_req_t       sh_req;
  logic [WIN_W-1:0] sh_out;

  // request decode
  op_e              op;
  logic [2:0]       bit_off;
  logic             len_ok;
  logic             fld_past;
  logic             idx_past;
  logic [CNT_W-1:0] span;
  logic [SH_W-1:0]  sh_fld;

  assign op       = op_e'(operation_i);
  assign bit_off  = bit_position_i[2:0];
  assign len_ok   = (field_length_i != '0) && (32'(field_length_i) <= MAX_FIELD_BITS);
  assign fld_past = (32'(bit_position_i) + 32'(field_length_i)) > TOTAL_BITS;
  assign idx_past = 32'(byte_index_i) >= BUFFER_BYTES;
  assign span     = CNT_W'((32'(bit_off) + 32'(field_length_i) + 32'd7) >> 3);
  // field sits s bits below the window MSB; sh is the distance of its LSB
  assign sh_fld   = SH_W'(WIN_W - 32'(bit_off) - 32'(field_length_i));

  bfei_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (mem_wr),
    .rd_i    (mem_rd),
    .rdata_o (rdata)
  );

  bfei_shift u_shift (
    .req_i  (sh_req),
    .word_o (sh_out)
  );

  always_comb begin
    logic [7:0]       merged;
    logic [VAL_W-1:0] fld;
    logic [VAL_W-1:0] sbit;

    state_d  = state_q;
    pend_d   = pend_q;
    rd_k_d   = rd_k_q;
    cap_k_d  = cap_k_q;
    set_d    = set_q;
    signed_d = signed_q;
    b0_d     = b0_q;
    n_d      = n_q;
    len_d    = len_q;
    sh_d     = sh_q;
    val_d    = val_q;
    data_d   = data_q;
    mask_d   = mask_q;
    win_d    = win_q;
    res_d    = res_q;
    status_d = status_q;

    merged = 8'h00;
    fld    = '0;
    sbit   = '0;

    mem_wr      = '0;
    mem_rd      = '0;
    sh_req      = '0;
    sh_req.amt  = sh_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d    = '0;
          status_d = 1'b0;
          state_d  = S_DONE;
          pend_d   = 1'b0;
          rd_k_d   = '0;
          cap_k_d  = '0;
          set_d    = 1'b0;
          signed_d = 1'b0;
          case (op)
            OP_LOAD_BYTE: begin
              if (idx_past) begin
                status_d = 1'b1;
              end else begin
                mem_wr.we   = 1'b1;
                mem_wr.addr = ADDR_W'(byte_index_i);
                mem_wr.data = write_value_i[7:0];
              end
            end
            OP_READ_BYTE: begin
              // handled as an unsigned 8-bit field on a byte boundary
              if (idx_past) begin
                status_d = 1'b1;
              end else begin
                b0_d    = ADDR_W'(byte_index_i);
                n_d     = CNT_W'(1);
                len_d   = LEN_W'(8);
                sh_d    = SH_W'(WIN_W - 8);
                state_d = S_BYTES;
              end
            end
            OP_GET_UNSIGNED, OP_GET_SIGNED, OP_SET_FIELD: begin
              if (!len_ok) begin
                // zero or overlong length: nothing done, reads zero
              end else if (fld_past) begin
                status_d = 1'b1;
              end else begin
                b0_d     = ADDR_W'(bit_position_i >> 3);
                n_d      = span;
                len_d    = field_length_i;
                sh_d     = sh_fld;
                val_d    = write_value_i;
                signed_d = (op == OP_GET_SIGNED);
                set_d    = (op == OP_SET_FIELD);
                state_d  = (op == OP_SET_FIELD) ? S_ALIGN_D : S_BYTES;
              end
            end
            default: ;
          endcase
        end
      end

      S_ALIGN_D: begin
        sh_req.word = WIN_W'(val_q & len_mask(len_q));
        sh_req.left = 1'b1;
        data_d      = sh_out;
        state_d     = S_ALIGN_M;
      end

      S_ALIGN_M: begin
        sh_req.word = WIN_W'(len_mask(len_q));
        sh_req.left = 1'b1;
        mask_d      = sh_out;
        state_d     = S_BYTES;
      end

      S_BYTES: begin
        if (rd_k_q < n_q) begin
          mem_rd.re   = 1'b1;
          mem_rd.addr = ADDR_W'(b0_q + ADDR_W'(rd_k_q));
          rd_k_d      = rd_k_q + CNT_W'(1);
        end
        pend_d = mem_rd.re;
        if (pend_q) begin
          for (int l = 0; l < MAX_SPAN; l++) begin
            if (cap_k_q == CNT_W'(l)) begin
              win_d[WIN_W-8-8*l +: 8] = rdata;
              merged = (rdata & ~mask_q[WIN_W-8-8*l +: 8])
                     | (data_q[WIN_W-8-8*l +: 8] & mask_q[WIN_W-8-8*l +: 8]);
            end
          end
          mem_wr.we   = set_q;
          mem_wr.addr = ADDR_W'(b0_q + ADDR_W'(cap_k_q));
          mem_wr.data = merged;
          cap_k_d     = cap_k_q + CNT_W'(1);
          if (cap_k_q == n_q - CNT_W'(1)) begin
            state_d = set_q ? S_DONE : S_EXTRACT;
          end
        end
      end

      S_EXTRACT: begin
        sh_req.word = win_q;
        sh_req.left = 1'b0;
        fld = VAL_W'(sh_out) & len_mask(len_q);
        if (signed_q) begin
          sbit = VAL_W'(1) << (len_q - LEN_W'(1));
          fld  = (fld ^ sbit) - sbit;
        end
        res_d   = fld;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      rd_k_q  <= '0;
      cap_k_q <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      rd_k_q  <= rd_k_d;
      cap_k_q <= cap_k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_q    <= set_d;
    signed_q <= signed_d;
    b0_q     <= b0_d;
    n_q      <= n_d;
    len_q    <= len_d;
    sh_q     <= sh_d;
    val_q    <= val_d;
    data_q   <= data_d;
    mask_q   <= mask_d;
    win_q    <= win_d;
    res_q    <= res_d;
    status_q <= status_d;
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = (state_q == S_DONE);
  assign result_value_o = res_q;
  assign status_o       = status_q;

endmodule
